### hdl/touch_velocity_window_tracker_defines.svh
// Assertion macros shared by the touch velocity window tracker.
`ifndef TOUCH_VELOCITY_WINDOW_TRACKER_DEFINES_SVH
`define TOUCH_VELOCITY_WINDOW_TRACKER_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define TVWT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvwt: same-cycle check failed");

// The antecedent implies the consequent in the next cycle.
`define TVWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvwt: next-cycle check failed");

`endif

### hdl/tvwt_pkg.sv
// Shared constants and types of the touch velocity window tracker.
package tvwt_pkg;

    localparam int WINDOW_FRAMES = 4;
    localparam int TOUCH_SLOTS   = 5;
    localparam int FIELD_SLOTS   = 5;
    localparam int OLD_TAP       = WINDOW_FRAMES - 2;

    localparam int COUNT_W = 3;
    localparam int DATA_W  = 16;
    localparam int VEL_W   = DATA_W + 1;
    localparam int LIMIT_W = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

    typedef logic [DATA_W-1:0]        data_t;
    typedef logic signed [VEL_W-1:0]  vel_t;

    // Control passed from the top level to the no-change counter.
    typedef struct packed {
        logic changed;
        logic advance;
    } still_ctrl_t;

endpackage

### hdl/tvwt_still.sv
// No-change counter and its limit register.
module tvwt_still (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [tvwt_pkg::LIMIT_W-1:0] cfg_data,
    input  tvwt_pkg::still_ctrl_t        ctrl,
    output logic                         forced
);

    logic [tvwt_pkg::LIMIT_W-1:0] limit_reg;
    logic [tvwt_pkg::LIMIT_W-1:0] still_reg;
    logic [tvwt_pkg::LIMIT_W-1:0] still_next;

    // An unchanged frame goes through when the count has reached the limit.
    assign forced = !ctrl.changed && (still_reg == limit_reg);

    always_comb
    begin
        still_next = still_reg;
        if (ctrl.advance)
        begin
            if (ctrl.changed)
                still_next = '0;
            else if (forced)
                still_next = tvwt_pkg::LIMIT_W'(1);
            else
                still_next = still_reg + tvwt_pkg::LIMIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tvwt_pkg::LIMIT_RESET;
            still_reg <= '0;
        end
        else
        begin
            if (cfg_write)
                limit_reg <= cfg_data;
            still_reg <= still_next;
        end
    end

endmodule

### hdl/tvwt_lane.sv
// One touch slot: its window of past frames, change test and velocities.
module tvwt_lane (
    input  logic            clk,
    input  logic            rst_n,
    input  tvwt_pkg::data_t loc,
    input  tvwt_pkg::data_t size,
    input  logic            commit,
    output logic            differs,
    output tvwt_pkg::vel_t  loc_vel,
    output tvwt_pkg::vel_t  size_vel
);

    // Tap zero holds the newest frame, the last tap the oldest.
    tvwt_pkg::data_t loc_tap_reg  [tvwt_pkg::WINDOW_FRAMES];
    tvwt_pkg::data_t size_tap_reg [tvwt_pkg::WINDOW_FRAMES];

    logic            fill;
    tvwt_pkg::data_t loc_old;
    tvwt_pkg::data_t size_old;

    assign differs = (loc != loc_tap_reg[0]) || (size != size_tap_reg[0]);

    // After the shift the tap before last becomes the oldest frame.
    assign fill     = (size != '0) != (size_tap_reg[tvwt_pkg::OLD_TAP] != '0);
    assign loc_old  = fill ? loc  : loc_tap_reg[tvwt_pkg::OLD_TAP];
    assign size_old = fill ? size : size_tap_reg[tvwt_pkg::OLD_TAP];

    assign loc_vel  = tvwt_pkg::vel_t'({1'b0, loc})  - tvwt_pkg::vel_t'({1'b0, loc_old});
    assign size_vel = tvwt_pkg::vel_t'({1'b0, size}) - tvwt_pkg::vel_t'({1'b0, size_old});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < tvwt_pkg::WINDOW_FRAMES; k++)
            begin
                loc_tap_reg[k]  <= '0;
                size_tap_reg[k] <= '0;
            end
        end
        else if (commit)
        begin
            loc_tap_reg[0]  <= loc;
            size_tap_reg[0] <= size;
            for (int k = 1; k < tvwt_pkg::WINDOW_FRAMES; k++)
            begin
                loc_tap_reg[k]  <= fill ? loc  : loc_tap_reg[k-1];
                size_tap_reg[k] <= fill ? size : size_tap_reg[k-1];
            end
        end
    end

endmodule

### hdl/touch_velocity_window_tracker.sv
// Top level of the touch velocity window tracker.
//
//  Channel  Handshake             Payload
//  -------  --------------------  ------------------------------------------
//  input    in_valid / in_stall   touch_count, loc_a..loc_e, size_a..size_e
//  output   out_valid / out_stall loc_vel_a..loc_vel_e, size_vel_a..size_vel_e
//  config   cfg_write             cfg_data (no-change limit)
//
// A frame beat is captured in the input register, and from there one pass
// of logic masks it, tests it against the newest stored frame and, when it
// yields a result, updates the windows and loads the result register; one
// frame per cycle sustained while out_stall is low.
// Reset clears the windows, the no-change counter and both valid flags, and
// sets the limit to three.
// A frame that yields a result waits in the input register while the result
// register is held by out_stall; a frame that yields nothing never waits.
module touch_velocity_window_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tvwt_pkg::LIMIT_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tvwt_pkg::COUNT_W-1:0]        touch_count,
    input  logic [tvwt_pkg::DATA_W-1:0]         loc_a,
    input  logic [tvwt_pkg::DATA_W-1:0]         loc_b,
    input  logic [tvwt_pkg::DATA_W-1:0]         loc_c,
    input  logic [tvwt_pkg::DATA_W-1:0]         loc_d,
    input  logic [tvwt_pkg::DATA_W-1:0]         loc_e,
    input  logic [tvwt_pkg::DATA_W-1:0]         size_a,
    input  logic [tvwt_pkg::DATA_W-1:0]         size_b,
    input  logic [tvwt_pkg::DATA_W-1:0]         size_c,
    input  logic [tvwt_pkg::DATA_W-1:0]         size_d,
    input  logic [tvwt_pkg::DATA_W-1:0]         size_e,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tvwt_pkg::VEL_W-1:0]   loc_vel_a,
    output logic signed [tvwt_pkg::VEL_W-1:0]   loc_vel_b,
    output logic signed [tvwt_pkg::VEL_W-1:0]   loc_vel_c,
    output logic signed [tvwt_pkg::VEL_W-1:0]   loc_vel_d,
    output logic signed [tvwt_pkg::VEL_W-1:0]   loc_vel_e,
    output logic signed [tvwt_pkg::VEL_W-1:0]   size_vel_a,
    output logic signed [tvwt_pkg::VEL_W-1:0]   size_vel_b,
    output logic signed [tvwt_pkg::VEL_W-1:0]   size_vel_c,
    output logic signed [tvwt_pkg::VEL_W-1:0]   size_vel_d,
    output logic signed [tvwt_pkg::VEL_W-1:0]   size_vel_e
);

`include "touch_velocity_window_tracker_defines.svh"

    // The input fields gathered into arrays by slot.
    tvwt_pkg::data_t loc_in  [tvwt_pkg::FIELD_SLOTS];
    tvwt_pkg::data_t size_in [tvwt_pkg::FIELD_SLOTS];

    // Input register.
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [tvwt_pkg::COUNT_W-1:0] count_reg;
    tvwt_pkg::data_t              loc_in_reg  [tvwt_pkg::FIELD_SLOTS];
    tvwt_pkg::data_t              size_in_reg [tvwt_pkg::FIELD_SLOTS];

    // Per-slot results of the single pass.
    logic [tvwt_pkg::FIELD_SLOTS-1:0] lane_differs;
    tvwt_pkg::vel_t                   loc_vel  [tvwt_pkg::FIELD_SLOTS];
    tvwt_pkg::vel_t                   size_vel [tvwt_pkg::FIELD_SLOTS];

    // Result register.
    logic           out_valid_reg;
    logic           out_valid_next;
    tvwt_pkg::vel_t loc_vel_reg  [tvwt_pkg::FIELD_SLOTS];
    tvwt_pkg::vel_t size_vel_reg [tvwt_pkg::FIELD_SLOTS];

    logic                  in_accept;
    logic                  changed;
    logic                  forced;
    logic                  emits;
    logic                  out_free;
    logic                  advance;
    logic                  commit;
    tvwt_pkg::still_ctrl_t still_ctrl;

    assign loc_in[0]  = loc_a;
    assign loc_in[1]  = loc_b;
    assign loc_in[2]  = loc_c;
    assign loc_in[3]  = loc_d;
    assign loc_in[4]  = loc_e;
    assign size_in[0] = size_a;
    assign size_in[1] = size_b;
    assign size_in[2] = size_c;
    assign size_in[3] = size_d;
    assign size_in[4] = size_e;

    // Each slot compares its masked frame with its newest stored frame and
    // forms its two velocities. Slots beyond the configured number of touch
    // slots hold nothing and report zero.
    for (genvar i = 0; i < tvwt_pkg::FIELD_SLOTS; i++)
    begin : g_slot
        if (i < tvwt_pkg::TOUCH_SLOTS)
        begin : g_lane
            logic            active;
            tvwt_pkg::data_t loc_m;
            tvwt_pkg::data_t size_m;

            // A slot at or above the touch count is forced to zero.
            assign active = count_reg > tvwt_pkg::COUNT_W'(i);
            assign loc_m  = active ? loc_in_reg[i]  : '0;
            assign size_m = active ? size_in_reg[i] : '0;

            tvwt_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .loc      (loc_m),
                .size     (size_m),
                .commit   (commit),
                .differs  (lane_differs[i]),
                .loc_vel  (loc_vel[i]),
                .size_vel (size_vel[i])
            );
        end
        else
        begin : g_unused
            assign lane_differs[i] = 1'b0;
            assign loc_vel[i]      = '0;
            assign size_vel[i]     = '0;
        end
    end

    assign changed = |lane_differs;
    assign emits   = changed || forced;

    // The result register is free when empty or when its beat leaves now.
    assign out_free = !out_valid_reg || !out_stall;

    // A frame that gives no result leaves at once; one that gives a result
    // needs room in the result register.
    assign advance = in_valid_reg && (!emits || out_free);
    assign commit  = advance && emits;

    assign still_ctrl.changed = changed;
    assign still_ctrl.advance = advance;

    tvwt_still u_still (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .ctrl      (still_ctrl),
        .forced    (forced)
    );

    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            count_reg <= touch_count;
            for (int k = 0; k < tvwt_pkg::FIELD_SLOTS; k++)
            begin
                loc_in_reg[k]  <= loc_in[k];
                size_in_reg[k] <= size_in[k];
            end
        end
        if (commit)
        begin
            for (int k = 0; k < tvwt_pkg::FIELD_SLOTS; k++)
            begin
                loc_vel_reg[k]  <= loc_vel[k];
                size_vel_reg[k] <= size_vel[k];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign loc_vel_a  = loc_vel_reg[0];
    assign loc_vel_b  = loc_vel_reg[1];
    assign loc_vel_c  = loc_vel_reg[2];
    assign loc_vel_d  = loc_vel_reg[3];
    assign loc_vel_e  = loc_vel_reg[4];
    assign size_vel_a = size_vel_reg[0];
    assign size_vel_b = size_vel_reg[1];
    assign size_vel_c = size_vel_reg[2];
    assign size_vel_d = size_vel_reg[3];
    assign size_vel_e = size_vel_reg[4];

    // A committed frame always shows up as a result beat next cycle.
    `TVWT_ASSERT_NEXT(a_commit_shows, commit, out_valid_reg)
    // An empty input register never holds the upstream side back.
    `TVWT_ASSERT_SAME(a_stall_needs_frame, !in_valid_reg, !in_stall)
    // A result beat taken with nothing new behind it empties the register.
    `TVWT_ASSERT_NEXT(a_drain_empties, out_valid_reg && !out_stall && !commit, !out_valid_reg)

endmodule
